>>> rtl/mgd_pkg.sv
// Shared types and constants for the motion gesture detector.
`timescale 1ns / 1ps
package mgd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_UPDATE,
      ST_MULTIPLY,
      ST_COMMIT
   } state_type;

   // One product per step on the shared multiplier.
   typedef enum logic [3:0] {
      MS_FX2, MS_FY2, MS_FZ2,
      MS_DX,  MS_DY,  MS_DZ,
      MS_VX2, MS_VY2, MS_VZ2,
      MS_D2,
      MS_AX2, MS_AY2, MS_AZ2,
      MS_T2,  MS_LIM,
      MS_FLUSH
   } mul_step_type;

   typedef struct packed {
      logic         load;
      logic         div_step;
      logic         filt_update;
      logic         mul_en;
      mul_step_type mul_step;
      logic         commit;
   } cmd_type;

   localparam logic [2:0] CSR_ORIENT_EN  = 3'd0;
   localparam logic [2:0] CSR_REF_X      = 3'd1;
   localparam logic [2:0] CSR_REF_Y      = 3'd2;
   localparam logic [2:0] CSR_REF_Z      = 3'd3;
   localparam logic [2:0] CSR_SLAP_THR   = 3'd4;
   localparam logic [2:0] CSR_SHAKE_THR  = 3'd5;

   localparam logic [1:0] SHAKE_IDLE = 2'd0;
   localparam logic [1:0] SHAKE_POS  = 2'd1;
   localparam logic [1:0] SHAKE_NEG  = 2'd2;
   localparam logic [1:0] SHAKE_COUNT = 2'd3;

   localparam logic [39:0] WIN_LO_SQ = 40'd482016 * 40'd482016;
   localparam logic [39:0] WIN_HI_SQ = 40'd803360 * 40'd803360;
   localparam logic [22:0] G2_Q16    = 23'd6302622;

   localparam logic [15:0] HOLD_MS         = 16'd400;
   localparam logic [15:0] SLAP_LOCK_MS    = 16'd500;
   localparam logic [15:0] SHAKE_SPAN_MS   = 16'd650;

   localparam logic [11:0] SLAP_THR_RESET  = 12'd640;
   localparam logic [14:0] SHAKE_THR_RESET = 15'd1792;

endpackage

>>> rtl/mgd_controller.sv
// Sequencer for load, divide, filter update, multiply and commit phases.
`timescale 1ns / 1ps
module mgd_controller (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic            rsp_tready,
   output logic            rsp_tvalid,
   output mgd_pkg::cmd_type cmd
);
   import mgd_pkg::*;

   // One divide step per axis.
   localparam int DIV_STEPS = 3;
   localparam int CNT_W     = 4;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd          = '0;
      cmd.mul_step = mul_step_type'(count_ff[3:0]);
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (count_ff == CNT_W'(DIV_STEPS - 1)) begin
               count_in = '0;
               state_in = ST_UPDATE;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.filt_update = 1'b1;
            state_in = ST_MULTIPLY;
         end
         ST_MULTIPLY: begin
            cmd.mul_en = 1'b1;
            if (mul_step_type'(count_ff[3:0]) == MS_FLUSH) begin
               count_in = '0;
               state_in = ST_COMMIT;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_tready);
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_load_starts_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_DIVIDE && count_ff == '0)
      else $error("load did not start the divide phase");

   a_update_after_full_divide: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> $past(state_ff) == ST_DIVIDE &&
                                $past(count_ff) == CNT_W'(DIV_STEPS - 1))
      else $error("filter update without a complete divide");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready)
      else $error("input taken while busy");

endmodule

>>> rtl/mgd_datapath.sv
// Filter, shared multiplier, accumulators, gesture state and result register.
`timescale 1ns / 1ps
module mgd_datapath #(
   parameter int SAMPLE_BITS = 16,
   parameter int TIME_BITS   = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SAMPLE_BITS-1:0] accel_x,
   input  logic [SAMPLE_BITS-1:0] accel_y,
   input  logic [SAMPLE_BITS-1:0] accel_z,
   input  logic [TIME_BITS-1:0]   time_ms,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_data,
   input  mgd_pkg::cmd_type       cmd,
   output logic                   slap_pulse,
   output logic                   shake_pulse,
   output logic                   is_upside_down
);
   import mgd_pkg::*;

   localparam int SB   = SAMPLE_BITS;
   localparam int TB   = TIME_BITS;
   localparam int FW   = SB + 8;
   localparam int UW   = FW + 3;
   localparam int DW   = SB + 18;
   localparam int MW   = DW;
   localparam int PW   = 2 * MW;
   localparam int M2W  = 2 * FW + 2;
   localparam int MMW  = 2 * SB + 2;
   localparam int CMPW = 2 * DW + 7;
   localparam int SLW  = (2 * SB + 18 > 47) ? 2 * SB + 18 : 47;
   localparam int LW   = ((SB > 16) ? SB : 16) + 1;
   localparam logic [UW-1:0] DIV_BIAS = UW'(5) << FW;
   // Reciprocal of five: shift RK is 2 mod 4 and covers the numerator, so
   // (2^RK + 1) / 5 is exact and the product shifted right by RK is the floor.
   localparam int RK   = UW + ((6 - (UW % 4)) % 4);
   localparam int RW   = RK - 2;
   localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RK) + 64'd1) / 64'd5);

   // configuration
   logic                     orient_en_ff;
   logic signed [15:0]       ref_ff [3];
   logic [11:0]              slap_thr_ff;
   logic [14:0]              shake_thr_ff;

   // sample and filter
   logic signed [SB-1:0]     a_ff [3];
   logic [TB-1:0]            now_ff;
   logic signed [FW-1:0]     f_ff [3];
   logic                     primed_ff;
   logic [UW-1:0]            div_ff [3];
   logic [UW+RW-1:0]         quo_prod;
   logic signed [SB-1:0]     sample [3];

   // multiplier and accumulators
   logic signed [MW-1:0]     op_a, op_b;
   logic signed [PW-1:0]     prod_in, prod_ff;
   mul_step_type             pstep_ff;
   logic                     pvalid_ff;
   logic [M2W-1:0]           m2_ff;
   logic signed [DW-1:0]     d_ff;
   logic [MMW-1:0]           mv_ff;
   logic [2*DW-1:0]          d2_ff;
   logic [MMW-1:0]           r2_ff;
   logic [46:0]              lim_ff;

   // gesture state
   logic                     upside_ff, upside_in;
   logic                     cand_ff, cand_in;
   logic [TB-1:0]            since_ff, since_in;
   logic [TB-1:0]            last_slap_ff, last_slap_in;
   logic [1:0]               dir_ff, dir_in;
   logic [TB-1:0]            window_ff, window_in;
   logic [1:0]               rev_ff, rev_in;
   logic                     slap_in, shake_in;

   logic                     slap_ff, shake_ff, upside_out_ff;

   assign sample[0] = accel_x;
   assign sample[1] = accel_y;
   assign sample[2] = accel_z;

   // Divide by five through the reciprocal multiply, one axis per cycle; the
   // biased numerators rotate past the multiplier and come back as quotients.
   assign quo_prod = div_ff[0] * RECIP;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i]   <= sample[i];
            div_ff[i] <= (UW'(f_ff[i]) << 2) + (UW'(sample[i]) << 8) + UW'(2) + DIV_BIAS;
         end
         now_ff <= time_ms;
      end else if (cmd.div_step) begin
         div_ff[0] <= div_ff[1];
         div_ff[1] <= div_ff[2];
         div_ff[2] <= UW'(quo_prod[UW+RW-1:RK]);
      end
      if (cmd.filt_update) begin
         for (int i = 0; i < 3; i++) begin
            f_ff[i] <= primed_ff ? signed'(div_ff[i][FW-1:0]) : signed'({a_ff[i], 8'd0});
         end
      end
   end

   // Operand select for the shared multiplier.
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (cmd.mul_step)
         MS_FX2: begin op_a = MW'(f_ff[0]); op_b = MW'(f_ff[0]); end
         MS_FY2: begin op_a = MW'(f_ff[1]); op_b = MW'(f_ff[1]); end
         MS_FZ2: begin op_a = MW'(f_ff[2]); op_b = MW'(f_ff[2]); end
         MS_DX:  begin op_a = MW'(ref_ff[0]); op_b = MW'(signed'(f_ff[0][FW-1:8])); end
         MS_DY:  begin op_a = MW'(ref_ff[1]); op_b = MW'(signed'(f_ff[1][FW-1:8])); end
         MS_DZ:  begin op_a = MW'(ref_ff[2]); op_b = MW'(signed'(f_ff[2][FW-1:8])); end
         MS_VX2: begin
            op_a = MW'(signed'(f_ff[0][FW-1:8]));
            op_b = MW'(signed'(f_ff[0][FW-1:8]));
         end
         MS_VY2: begin
            op_a = MW'(signed'(f_ff[1][FW-1:8]));
            op_b = MW'(signed'(f_ff[1][FW-1:8]));
         end
         MS_VZ2: begin
            op_a = MW'(signed'(f_ff[2][FW-1:8]));
            op_b = MW'(signed'(f_ff[2][FW-1:8]));
         end
         MS_D2:  begin op_a = MW'(d_ff); op_b = MW'(d_ff); end
         MS_AX2: begin op_a = MW'(a_ff[0]); op_b = MW'(a_ff[0]); end
         MS_AY2: begin op_a = MW'(a_ff[1]); op_b = MW'(a_ff[1]); end
         MS_AZ2: begin op_a = MW'(a_ff[2]); op_b = MW'(a_ff[2]); end
         MS_T2:  begin op_a = MW'({1'b0, slap_thr_ff}); op_b = MW'({1'b0, slap_thr_ff}); end
         MS_LIM: begin op_a = MW'({1'b0, prod_ff[23:0]}); op_b = MW'({1'b0, G2_Q16}); end
         MS_FLUSH: begin op_a = '0; op_b = '0; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= cmd.mul_en;
      end
      prod_ff  <= prod_in;
      pstep_ff <= cmd.mul_step;
      if (cmd.load) begin
         m2_ff <= '0;
         d_ff  <= '0;
         mv_ff <= '0;
         r2_ff <= '0;
      end else if (pvalid_ff) begin
         unique case (pstep_ff)
            MS_FX2, MS_FY2, MS_FZ2: m2_ff <= m2_ff + prod_ff[M2W-1:0];
            MS_DX, MS_DY, MS_DZ:    d_ff  <= d_ff + signed'(prod_ff[DW-1:0]);
            MS_VX2, MS_VY2, MS_VZ2: mv_ff <= mv_ff + prod_ff[MMW-1:0];
            MS_D2:                  d2_ff <= prod_ff[2*DW-1:0];
            MS_AX2, MS_AY2, MS_AZ2: r2_ff <= r2_ff + prod_ff[MMW-1:0];
            MS_LIM:                 lim_ff <= prod_ff[46:0];
            MS_T2, MS_FLUSH: ;
            default: ;
         endcase
      end
   end

   // Decision logic on the finished sums.
   always_comb begin
      logic              win, target, d_neg, d_pos, pos, neg, rev;
      logic [CMPW-1:0]   hundred, mm, nine;
      logic [SLW-1:0]    lhs, rhs;
      logic [SB-1:0]     abs_x, abs_y;
      logic signed [LW-1:0] lat, thr;
      logic [TB-1:0]     age;

      win     = (m2_ff >= M2W'(WIN_LO_SQ)) && (m2_ff <= M2W'(WIN_HI_SQ));
      d_neg   = d_ff[DW-1];
      d_pos   = !d_neg && (d_ff != '0);
      hundred = (CMPW'(d2_ff) << 6) + (CMPW'(d2_ff) << 5) + (CMPW'(d2_ff) << 2);
      mm      = CMPW'(mv_ff) << 28;
      nine    = (mm << 3) + mm;

      upside_in = upside_ff;
      cand_in   = cand_ff;
      since_in  = since_ff;
      target    = upside_ff;
      if (!upside_ff && d_neg && hundred > nine) begin
         target = 1'b1;
      end else if (upside_ff && d_pos && hundred > mm) begin
         target = 1'b0;
      end
      if (orient_en_ff && win) begin
         if (target != cand_ff) begin
            cand_in  = target;
            since_in = now_ff;
         end else if (target != upside_ff && (now_ff - since_ff) >= TB'(HOLD_MS)) begin
            upside_in = target;
         end
      end

      lhs          = SLW'(r2_ff) << 16;
      rhs          = SLW'(lim_ff);
      slap_in      = 1'b0;
      last_slap_in = last_slap_ff;
      if (lhs >= rhs && (last_slap_ff == '0 ||
                         (now_ff - last_slap_ff) > TB'(SLAP_LOCK_MS))) begin
         slap_in      = 1'b1;
         last_slap_in = (now_ff == '0) ? TB'(1) : now_ff;
      end

      abs_x = a_ff[0][SB-1] ? SB'(-a_ff[0]) : a_ff[0];
      abs_y = a_ff[1][SB-1] ? SB'(-a_ff[1]) : a_ff[1];
      lat   = (abs_x > abs_y) ? LW'(a_ff[0]) : LW'(a_ff[1]);
      thr   = signed'(LW'(shake_thr_ff));
      pos   = lat > thr;
      neg   = lat < -thr;
      age   = now_ff - window_ff;
      rev   = (dir_ff == SHAKE_POS && neg) || (dir_ff != SHAKE_POS && pos);

      shake_in  = 1'b0;
      dir_in    = dir_ff;
      window_in = window_ff;
      rev_in    = rev_ff;
      if (dir_ff == SHAKE_IDLE) begin
         if (pos || neg) begin
            dir_in    = pos ? SHAKE_POS : SHAKE_NEG;
            window_in = now_ff;
            rev_in    = '0;
         end
      end else if (rev) begin
         dir_in = pos ? SHAKE_POS : SHAKE_NEG;
         if (age > TB'(SHAKE_SPAN_MS)) begin
            window_in = now_ff;
            rev_in    = 2'd1;
         end else if (rev_ff + 2'd1 >= SHAKE_COUNT) begin
            shake_in = 1'b1;
            rev_in   = '0;
            dir_in   = SHAKE_IDLE;
         end else begin
            rev_in = rev_ff + 2'd1;
         end
      end else if (age > TB'(SHAKE_SPAN_MS)) begin
         rev_in = '0;
         dir_in = SHAKE_IDLE;
      end
   end

   // Commit sample state, or else take a configuration write; a write in a commit cycle is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         orient_en_ff <= 1'b0;
         ref_ff[0]    <= '0;
         ref_ff[1]    <= '0;
         ref_ff[2]    <= '0;
         slap_thr_ff  <= SLAP_THR_RESET;
         shake_thr_ff <= SHAKE_THR_RESET;
         primed_ff    <= 1'b0;
         upside_ff    <= 1'b0;
         cand_ff      <= 1'b0;
         since_ff     <= '0;
         last_slap_ff <= '0;
         dir_ff       <= SHAKE_IDLE;
         window_ff    <= '0;
         rev_ff       <= '0;
      end else begin
         if (cmd.filt_update) begin
            primed_ff <= 1'b1;
         end
         if (cmd.commit) begin
            upside_ff    <= upside_in;
            cand_ff      <= cand_in;
            since_ff     <= since_in;
            last_slap_ff <= last_slap_in;
            dir_ff       <= dir_in;
            window_ff    <= window_in;
            rev_ff       <= rev_in;
         end else if (csr_we) begin
            unique case (csr_index)
               CSR_ORIENT_EN: begin
                  orient_en_ff <= csr_data[0];
                  if (!csr_data[0]) begin
                     upside_ff <= 1'b0;
                     cand_ff   <= 1'b0;
                     since_ff  <= '0;
                  end
               end
               CSR_REF_X:     ref_ff[0]    <= signed'(csr_data);
               CSR_REF_Y:     ref_ff[1]    <= signed'(csr_data);
               CSR_REF_Z:     ref_ff[2]    <= signed'(csr_data);
               CSR_SLAP_THR:  slap_thr_ff  <= csr_data[11:0];
               CSR_SHAKE_THR: shake_thr_ff <= csr_data[14:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         slap_ff       <= slap_in;
         shake_ff      <= shake_in;
         upside_out_ff <= upside_in;
      end
   end

   assign slap_pulse     = slap_ff;
   assign shake_pulse    = shake_ff;
   assign is_upside_down = upside_out_ff;

endmodule

>>> rtl/motion_gesture_detector_unit.sv
// Top level of the motion gesture detector.
`timescale 1ns / 1ps
// Takes one timestamped three-axis acceleration sample per req transaction and
// returns one rsp transaction with slap, shake and debounced upside-down flags.
// After the sample is accepted, the block divides the filter sums by five, one
// axis per cycle through a reciprocal multiplier, then loads the filter, then
// runs the single shared multiplier that forms every square and dot product
// (15 products plus a flush step to land the last), then commits the result
// to the output register. The next sample is taken the cycle after commit,
// while that result may still wait in the output register, so no new sample is
// accepted while one is in flight; a result the receiver has not taken holds the
// following sample in its commit step. Write configuration only while no sample
// is in flight; csr writes are always accepted.
module motion_gesture_detector_unit #(
   parameter int SAMPLE_BITS = 16,
   parameter int TIME_BITS   = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // accel_x, accel_y, accel_z, time_ms (lowest first), zero pad to bytes
   input  logic [((3*SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // slap_pulse, shake_pulse, is_upside_down (lowest first), zero pad
   output logic [7:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import mgd_pkg::*;

   localparam int SB = SAMPLE_BITS;

   cmd_type cmd;
   logic    slap, shake, upside;

   // Configuration never stalls.
   assign csr_ready = 1'b1;

   mgd_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   mgd_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .TIME_BITS(TIME_BITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .accel_x        (req_tdata[SB-1:0]),
      .accel_y        (req_tdata[2*SB-1:SB]),
      .accel_z        (req_tdata[3*SB-1:2*SB]),
      .time_ms        (req_tdata[3*SB+TIME_BITS-1:3*SB]),
      .csr_we         (csr_valid & csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .slap_pulse     (slap),
      .shake_pulse    (shake),
      .is_upside_down (upside)
   );

   assign rsp_tdata = {5'd0, upside, shake, slap};

endmodule

>>> sim/motion_gesture_detector_unit_tb.sv
// Self-checking testbench for the motion gesture detector top level.
`timescale 1ns / 1ps
module motion_gesture_detector_unit_tb;
   import mgd_pkg::*;

   // Register indexes with no register behind them; writes must be ignored.
   localparam logic [2:0] CSR_SPARE_A = 3'd6;
   localparam logic [2:0] CSR_SPARE_B = 3'd7;

   // Cycles to let pass after the last result before touching registers.
   localparam int DRAIN_CYCLES = 60;
   // Long receiver hold-off that backs the block up into its input.
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct {
      bit slap;
      bit shake;
      bit upside;
   } gesture_flags_type;

   typedef enum {SEQ_GRAVITY, SEQ_SHAKE, SEQ_SLAP, SEQ_NOISE} seq_kind_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   motion_gesture_detector_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Scoreboard: carries its own copy of the detector state and predicts the
   // flags of every accepted sample.
   class gesture_scoreboard;
      gesture_flags_type flags_q[$];
      int errors, samples, slaps, shakes, upsides;

      bit              orient_en;
      longint          ref_x, ref_y, ref_z;
      longint unsigned slap_thr, shake_thr;

      longint          filt_x, filt_y, filt_z;
      bit              primed;
      bit              upside, candidate;
      bit [31:0]       candidate_since;
      bit [31:0]       last_slap;
      logic [1:0]      shake_dir;
      bit [31:0]       shake_start;
      int              reversals;

      function new();
         orient_en = 0;
         ref_x = 0; ref_y = 0; ref_z = 0;
         slap_thr = SLAP_THR_RESET;
         shake_thr = SHAKE_THR_RESET;
         filt_x = 0; filt_y = 0; filt_z = 0;
         primed = 0;
         upside = 0; candidate = 0; candidate_since = 0;
         last_slap = 0;
         shake_dir = SHAKE_IDLE;
         shake_start = 0;
         reversals = 0;
      endfunction

      function longint floor_div(longint n, longint d);
         longint q;
         q = n / d;
         if ((n % d) != 0 && n < 0) q--;
         return q;
      endfunction

      function longint unsigned square(longint v);
         longint unsigned a;
         a = (v < 0) ? -v : v;
         return a * a;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] value);
         case (idx)
            CSR_ORIENT_EN: begin
               orient_en = value[0];
               if (!orient_en) begin
                  upside = 0; candidate = 0; candidate_since = 0;
               end
            end
            CSR_REF_X:     ref_x = longint'($signed(value));
            CSR_REF_Y:     ref_y = longint'($signed(value));
            CSR_REF_Z:     ref_z = longint'($signed(value));
            CSR_SLAP_THR:  slap_thr = value[11:0];
            CSR_SHAKE_THR: shake_thr = value[14:0];
            default: ;
         endcase
      endfunction

      // Advance the predicted state by one sample and queue the flags it yields.
      function void note_sample(shortint ax, shortint ay, shortint az, bit [31:0] now);
         gesture_flags_type exp_flags;
         longint          vx, vy, vz, d, lat, thr;
         longint unsigned m2, d2, mm, r2, lim;
         bit              target, pos, neg;
         bit [31:0]       age;
         exp_flags.slap = 0;
         exp_flags.shake = 0;
         if (!primed) begin
            filt_x = 256 * longint'(ax);
            filt_y = 256 * longint'(ay);
            filt_z = 256 * longint'(az);
            primed = 1;
         end else begin
            filt_x = floor_div(4 * filt_x + 256 * longint'(ax) + 2, 5);
            filt_y = floor_div(4 * filt_y + 256 * longint'(ay) + 2, 5);
            filt_z = floor_div(4 * filt_z + 256 * longint'(az) + 2, 5);
         end

         if (orient_en) begin
            m2 = square(filt_x) + square(filt_y) + square(filt_z);
            if (m2 >= 64'd482016 * 64'd482016 && m2 <= 64'd803360 * 64'd803360) begin
               vx = floor_div(filt_x, 256);
               vy = floor_div(filt_y, 256);
               vz = floor_div(filt_z, 256);
               d = ref_x * vx + ref_y * vy + ref_z * vz;
               d2 = 64'd100 * square(d);
               mm = (square(vx) + square(vy) + square(vz)) << 28;
               target = upside;
               if (!upside && d < 0 && d2 > 64'd9 * mm) target = 1;
               else if (upside && d > 0 && d2 > mm) target = 0;
               if (target != candidate) begin
                  candidate = target;
                  candidate_since = now;
               end else if (target != upside) begin
                  age = now - candidate_since;
                  if (age >= HOLD_MS) upside = target;
               end
            end
         end

         r2 = square(ax) + square(ay) + square(az);
         lim = slap_thr * slap_thr * G2_Q16;
         age = now - last_slap;
         if ((r2 << 16) >= lim && (last_slap == 0 || age > SLAP_LOCK_MS)) begin
            exp_flags.slap = 1;
            last_slap = (now == 0) ? 32'd1 : now;
         end

         lat = (square(ax) > square(ay)) ? longint'(ax) : longint'(ay);
         thr = longint'(shake_thr);
         pos = lat > thr;
         neg = lat < -thr;
         age = now - shake_start;
         if (shake_dir == SHAKE_IDLE) begin
            if (pos || neg) begin
               shake_dir = pos ? SHAKE_POS : SHAKE_NEG;
               shake_start = now;
               reversals = 0;
            end
         end else if ((shake_dir == SHAKE_POS && neg) || (shake_dir != SHAKE_POS && pos)) begin
            shake_dir = pos ? SHAKE_POS : SHAKE_NEG;
            if (age > SHAKE_SPAN_MS) begin
               shake_start = now;
               reversals = 1;
            end else begin
               reversals++;
               if (reversals >= SHAKE_COUNT) begin
                  exp_flags.shake = 1;
                  reversals = 0;
                  shake_dir = SHAKE_IDLE;
               end
            end
         end else if (age > SHAKE_SPAN_MS) begin
            reversals = 0;
            shake_dir = SHAKE_IDLE;
         end

         exp_flags.upside = upside;
         flags_q.push_back(exp_flags);
         samples++;
         slaps += exp_flags.slap;
         shakes += exp_flags.shake;
         upsides += exp_flags.upside;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_flags(logic [7:0] data);
         gesture_flags_type e;
         if (flags_q.size() == 0) begin
            report($sformatf("unexpected result %h", data));
            return;
         end
         e = flags_q.pop_front();
         if (data[0] !== e.slap)
            report($sformatf("slap_pulse %b, predicted %b", data[0], e.slap));
         if (data[1] !== e.shake)
            report($sformatf("shake_pulse %b, predicted %b", data[1], e.shake));
         if (data[2] !== e.upside)
            report($sformatf("is_upside_down %b, predicted %b", data[2], e.upside));
      endtask

      function int pending();
         return flags_q.size();
      endfunction
   endclass

   gesture_scoreboard sb;

   // Receiver control and stimulus generator state.
   bit        stall_req;
   int        rx_gap;
   seq_kind_type seq_kind;
   int        seq_left, gsel, gscale, shake_axis, shake_sign;
   bit [31:0] now_ms;

   // Gravity directions, Q8 m/s^2 at about 1 g; pairs at 2k and 2k+1 are opposite.
   int grav_x[6] = '{0, 0, 2510, -2510, 1449, -1449};
   int grav_y[6] = '{0, 0, 0, 0, 1449, -1449};
   int grav_z[6] = '{2510, -2510, 0, 0, -1449, 1449};

   initial clock = 0;
   always #6 clock = ~clock;

   // Mostly short gaps, many zero, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic shortint clip16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return shortint'(v);
   endfunction

   function automatic int jitter(int n);
      return int'($urandom_range(0, 2 * n)) - n;
   endfunction

   // Offer one sample after a random gap; hold it until the block takes it.
   task send_sample(shortint ax, shortint ay, shortint az, bit [31:0] t);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 0;
      end
      @(negedge clock);
      req_tvalid = 1;
      req_tdata = {t, az, ay, ax};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      sb.note_sample(ax, ay, az, t);
   endtask

   task write_csr(logic [2:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_data = value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_valid = 0;
   endtask

   // Drop valid, wait for every predicted result, then let the pipeline drain.
   task wait_idle();
      @(negedge clock);
      req_tvalid = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Build the next sample from the running sequence: gravity holds and flips,
   // shakes, slaps or plain noise, with the timestamp advancing accordingly.
   task next_sample();
      shortint   ax, ay, az;
      int        amp, r;
      bit [31:0] dt;
      if (seq_left == 0) begin
         r = $urandom_range(0, 99);
         seq_kind = (r < 45) ? SEQ_GRAVITY : (r < 70) ? SEQ_SHAKE :
                    (r < 85) ? SEQ_SLAP : SEQ_NOISE;
         seq_left = $urandom_range(10, 60);
         gsel = $urandom_range(0, 5);
         gscale = $urandom_range(0, 3) == 0 ? $urandom_range(65, 135) : $urandom_range(95, 105);
         shake_axis = $urandom_range(0, 1);
      end
      seq_left--;
      case (seq_kind)
         SEQ_GRAVITY: begin
            if ($urandom_range(0, 24) == 0) gsel = gsel ^ 1;
            ax = clip16(grav_x[gsel] * gscale / 100 + jitter(120));
            ay = clip16(grav_y[gsel] * gscale / 100 + jitter(120));
            az = clip16(grav_z[gsel] * gscale / 100 + jitter(120));
            dt = $urandom_range(5, 25);
         end
         SEQ_SHAKE: begin
            if ($urandom_range(0, 9) < 6) shake_sign = -shake_sign;
            amp = int'(sb.shake_thr) + $urandom_range(1, 3000);
            if (shake_axis == 0) begin
               ax = clip16(shake_sign * amp);
               ay = clip16(jitter(300));
            end else begin
               ax = clip16(jitter(300));
               ay = clip16(shake_sign * amp);
            end
            az = clip16(2510 + jitter(300));
            dt = $urandom_range(20, 150);
         end
         SEQ_SLAP: begin
            ax = clip16(grav_x[gsel] + jitter(200));
            ay = clip16(grav_y[gsel] + jitter(200));
            az = clip16(grav_z[gsel] + jitter(200));
            if ($urandom_range(0, 3) == 0) begin
               amp = $urandom_range(0, 1) ? $urandom_range(6000, 32767)
                                          : -int'($urandom_range(6000, 32768));
               case ($urandom_range(0, 2))
                  0: ax = clip16(amp);
                  1: ay = clip16(amp);
                  default: az = clip16(amp);
               endcase
            end
            dt = $urandom_range(50, 400);
         end
         default: begin
            ax = shortint'($urandom_range(0, 65535));
            ay = shortint'($urandom_range(0, 65535));
            az = shortint'($urandom_range(0, 65535));
            dt = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1000);
         end
      endcase
      now_ms = now_ms + dt;
      send_sample(ax, ay, az, now_ms);
   endtask

   task run_samples(int n);
      repeat (n) next_sample();
   endtask

   // Receiver: random ready gaps, plus one long hold-off on request.
   initial begin
      rsp_tready = 0;
      rx_gap = 0;
      forever begin
         @(negedge clock);
         if (stall_req) begin
            rsp_tready = 0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            stall_req = 0;
         end
         if (rx_gap > 0) begin
            rsp_tready = 0;
            rx_gap--;
         end else begin
            rsp_tready = 1;
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_flags(rsp_tdata);
            rx_gap = pick_gap();
         end
      end
   end

   // Hard limit on the whole run.
   initial begin
      #(30_000_000);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      sb = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_valid = 0;
      csr_index = CSR_ORIENT_EN;
      csr_data = '0;
      stall_req = 0;
      seq_left = 0;
      seq_kind = SEQ_NOISE;
      gsel = 0; gscale = 100; shake_axis = 0; shake_sign = 1;
      now_ms = 32'd2000;
      repeat (10) @(negedge clock);
      reset = 0;

      // Directed: filter load, field extremes, slap at time zero and lockout,
      // a completed shake, a y-dominant start, window timeout, time extremes.
      send_sample(0, 0, 2510, 0);
      send_sample(32767, 32767, 32767, 0);
      send_sample(-32768, -32768, -32768, 100);
      send_sample(-32768, 32767, 0, 601);
      send_sample(3000, 0, 0, 700);
      send_sample(-3000, 0, 0, 800);
      send_sample(3000, 0, 0, 900);
      send_sample(0, -3000, 100, 1000);
      send_sample(0, 0, 0, 1700);
      send_sample(0, 0, 0, 32'hFFFF_FFFF);
      send_sample(0, 0, 0, 0);
      wait_idle();

      // Orientation on with the zero reference left from reset.
      write_csr(CSR_ORIENT_EN, 16'd1);
      run_samples(60);
      wait_idle();

      // Reference along +z, default thresholds; back the block up once.
      write_csr(CSR_REF_Z, 16'h4000);
      stall_req = 1;
      run_samples(350);
      wait_idle();

      // Reference along -z, zero thresholds.
      write_csr(CSR_REF_Z, 16'hC000);
      write_csr(CSR_SLAP_THR, 16'd0);
      write_csr(CSR_SHAKE_THR, 16'd0);
      run_samples(200);
      wait_idle();

      // Reference along +x, maximum thresholds.
      write_csr(CSR_REF_X, 16'h4000);
      write_csr(CSR_REF_Z, 16'h0000);
      write_csr(CSR_SLAP_THR, 16'hFFFF);
      write_csr(CSR_SHAKE_THR, 16'hFFFF);
      run_samples(150);
      wait_idle();

      // Orientation off, full-scale references, spare indexes ignored.
      write_csr(CSR_ORIENT_EN, 16'hFFFE);
      write_csr(CSR_REF_X, 16'h8000);
      write_csr(CSR_REF_Y, 16'h7FFF);
      write_csr(CSR_SLAP_THR, 16'd1000);
      write_csr(CSR_SHAKE_THR, 16'd900);
      write_csr(CSR_SPARE_A, 16'hFFFF);
      write_csr(CSR_SPARE_B, 16'h5A5A);
      run_samples(150);
      wait_idle();

      // Diagonal reference, defaults restored, timestamps across the wrap.
      write_csr(CSR_ORIENT_EN, 16'd1);
      write_csr(CSR_REF_X, 16'd9459);
      write_csr(CSR_REF_Y, 16'd9459);
      write_csr(CSR_REF_Z, 16'(-9459));
      write_csr(CSR_SLAP_THR, SLAP_THR_RESET);
      write_csr(CSR_SHAKE_THR, SHAKE_THR_RESET);
      now_ms = 32'hFFFF_F000;
      run_samples(450);
      wait_idle();

      repeat (100) @(posedge clock);
      if (sb.pending() != 0) sb.report("predicted result never arrived");
      $display("Run covered %0d samples over seven register settings with random stalls",
               sb.samples);
      $display("Predicted %0d slaps, %0d shakes and %0d upside-down results",
               sb.slaps, sb.shakes, sb.upsides);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/mgd_pkg.sv
rtl/mgd_controller.sv
rtl/mgd_datapath.sv
rtl/motion_gesture_detector_unit.sv
sim/motion_gesture_detector_unit_tb.sv
